### rtl/core/ps2m_pkg.sv
package ps2m_pkg;

  // coordinate range of the cursor
  localparam int COORD_WIDTH = 12;
  localparam int COORD_MAX   = (1 << COORD_WIDTH) - 1;

  // field widths
  localparam int BYTE_W     = 8;
  localparam int SIZE_W     = 13;
  localparam int BTN_W      = 3;
  localparam int WHEEL_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // width used for size and limit compares
  localparam int CMP_W = (SIZE_W > COORD_WIDTH) ? SIZE_W : COORD_WIDTH + 1;
  // signed width of cursor plus or minus a 9-bit move
  localparam int SUM_W  = COORD_WIDTH + 2;
  localparam int MOVE_W = BYTE_W + 1;

  // result payload packing
  localparam int OUT_FIELDS_W = 2 * COORD_WIDTH + BTN_W + WHEEL_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // protocol bytes and header bits
  localparam logic [BYTE_W-1:0] ACK_BYTE   = 8'hfa;
  localparam logic [BYTE_W-1:0] SYNC_MASK  = 8'hc8;
  localparam logic [BYTE_W-1:0] SYNC_VALUE = 8'h08;
  localparam int XSIGN_POS = 4;
  localparam int YSIGN_POS = 5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_MODE    = 2'd2;

  // register reset values
  localparam logic [SIZE_W-1:0] RESET_WIDTH  = 13'd1024;
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = 13'd768;

  // result kinds
  localparam logic KIND_MOTION = 1'b0;
  localparam logic KIND_WHEEL  = 1'b1;

  // packet decode phase
  typedef enum logic [4:0] {
    PH_ACK    = 5'b00001,
    PH_HEADER = 5'b00010,
    PH_XMOVE  = 5'b00100,
    PH_YMOVE  = 5'b01000,
    PH_WHEEL  = 5'b10000
  } phase_t;

  // configuration seen by the decoder
  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic              wheel_mode;
    logic              recentre;
  } cfg_t;

  // largest coordinate on a screen of the given size
  function automatic logic [COORD_WIDTH-1:0] limit_of(input logic [SIZE_W-1:0] size);
    logic [CMP_W-1:0] v;
    v = (size == '0) ? '0 : CMP_W'(size) - CMP_W'(1);
    if (v > CMP_W'(COORD_MAX)) begin
      v = CMP_W'(COORD_MAX);
    end
    return v[COORD_WIDTH-1:0];
  endfunction

  // centre coordinate of a screen of the given size
  function automatic logic [COORD_WIDTH-1:0] centre_of(input logic [SIZE_W-1:0] size);
    logic [CMP_W-1:0] v;
    v = CMP_W'(size >> 1);
    if (v > CMP_W'(COORD_MAX)) begin
      v = CMP_W'(COORD_MAX);
    end
    return v[COORD_WIDTH-1:0];
  endfunction

endpackage

### rtl/core/ps2m_cfg_regs.sv
module ps2m_cfg_regs
  import ps2m_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;
  logic              wheel_mode_r;
  logic              recentre_r;
  logic              wr_en;

  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid && cfg_ready;

  // register writes; a size write asks the decoder to recentre
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= RESET_WIDTH;
      height_r     <= RESET_HEIGHT;
      wheel_mode_r <= 1'b0;
      recentre_r   <= 1'b0;
    end else begin
      recentre_r <= 1'b0;
      if (wr_en) begin
        case (cfg_index)
          REG_SCREEN_WIDTH: begin
            width_r    <= cfg_data[SIZE_W-1:0];
            recentre_r <= 1'b1;
          end
          REG_SCREEN_HEIGHT: begin
            height_r   <= cfg_data[SIZE_W-1:0];
            recentre_r <= 1'b1;
          end
          REG_WHEEL_MODE: begin
            wheel_mode_r <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign cfg.width      = width_r;
  assign cfg.height     = height_r;
  assign cfg.wheel_mode = wheel_mode_r;
  assign cfg.recentre   = recentre_r;

endmodule

### rtl/core/ps2m_in_stage.sv
module ps2m_in_stage
  import ps2m_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,
  output logic              item_valid,
  output logic [BYTE_W-1:0] item_byte,
  input  logic              item_take
);

  logic              valid_r;
  logic [BYTE_W-1:0] byte_r;

  // room when empty or when the held byte leaves this cycle
  assign in_tready = !valid_r || item_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

  assign item_valid = valid_r;
  assign item_byte  = byte_r;

endmodule

### rtl/core/ps2m_decode.sv
module ps2m_decode
  import ps2m_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  item_valid,
  input  logic [BYTE_W-1:0]     item_byte,
  output logic                  item_take,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic                  out_tuser,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  phase_t                  phase_r, phase_nxt;
  logic [BYTE_W-1:0]       header_r, header_nxt;
  logic [BYTE_W-1:0]       xmove_r, xmove_nxt;
  logic [COORD_WIDTH-1:0]  cur_x_r, cur_x_nxt;
  logic [COORD_WIDTH-1:0]  cur_y_r, cur_y_nxt;
  logic                    emit;
  logic                    kind;
  logic [WHEEL_W-1:0]      wheel;

  logic                    out_valid_r;
  logic                    out_kind_r;
  logic [OUT_DATA_W-1:0]   out_data_r;

  logic [MOVE_W-1:0]       dx;
  logic [MOVE_W-1:0]       dy;
  logic [SUM_W-1:0]        sum_x;
  logic [SUM_W-1:0]        sum_y;
  logic [COORD_WIDTH-1:0]  lim_x;
  logic [COORD_WIDTH-1:0]  lim_y;
  logic [COORD_WIDTH-1:0]  new_x;
  logic [COORD_WIDTH-1:0]  new_y;

  // byte moves on when the result register can take its result and no
  // recenter is pending
  assign item_take = item_valid && !cfg.recentre && (!out_valid_r || out_tready);

  // sign-extended moves and clamped cursor
  assign dx    = {header_r[XSIGN_POS], xmove_r};
  assign dy    = {header_r[YSIGN_POS], item_byte};
  assign sum_x = {2'b00, cur_x_r} + {{(SUM_W-MOVE_W){dx[MOVE_W-1]}}, dx};
  assign sum_y = {2'b00, cur_y_r} - {{(SUM_W-MOVE_W){dy[MOVE_W-1]}}, dy};
  assign lim_x = limit_of(cfg.width);
  assign lim_y = limit_of(cfg.height);

  always_comb begin
    if (sum_x[SUM_W-1]) begin
      new_x = '0;
    end else if (sum_x[SUM_W-2:0] > {1'b0, lim_x}) begin
      new_x = lim_x;
    end else begin
      new_x = sum_x[COORD_WIDTH-1:0];
    end
    if (sum_y[SUM_W-1]) begin
      new_y = '0;
    end else if (sum_y[SUM_W-2:0] > {1'b0, lim_y}) begin
      new_y = lim_y;
    end else begin
      new_y = sum_y[COORD_WIDTH-1:0];
    end
  end

  // packet phase decode
  always_comb begin
    phase_nxt  = phase_r;
    header_nxt = header_r;
    xmove_nxt  = xmove_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    emit       = 1'b0;
    kind       = KIND_MOTION;
    wheel      = '0;
    case (phase_r)
      PH_ACK: begin
        if (item_byte == ACK_BYTE) begin
          phase_nxt = PH_HEADER;
        end
      end
      PH_HEADER: begin
        if ((item_byte & SYNC_MASK) == SYNC_VALUE) begin
          header_nxt = item_byte;
          phase_nxt  = PH_XMOVE;
        end
      end
      PH_XMOVE: begin
        xmove_nxt = item_byte;
        phase_nxt = PH_YMOVE;
      end
      PH_YMOVE: begin
        phase_nxt = cfg.wheel_mode ? PH_WHEEL : PH_HEADER;
        cur_x_nxt = new_x;
        cur_y_nxt = new_y;
        emit      = 1'b1;
      end
      PH_WHEEL: begin
        phase_nxt = PH_HEADER;
        emit      = 1'b1;
        kind      = KIND_WHEEL;
        wheel     = item_byte[WHEEL_W-1:0];
      end
      default: begin
        phase_nxt = PH_ACK;
      end
    endcase
  end

  // decode state, recentered after a size write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_ACK;
      header_r <= '0;
      xmove_r  <= '0;
      cur_x_r  <= centre_of(RESET_WIDTH);
      cur_y_r  <= centre_of(RESET_HEIGHT);
    end else if (cfg.recentre) begin
      cur_x_r <= centre_of(cfg.width);
      cur_y_r <= centre_of(cfg.height);
    end else if (item_take) begin
      phase_r  <= phase_nxt;
      header_r <= header_nxt;
      xmove_r  <= xmove_nxt;
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_take) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && emit) begin
      out_kind_r <= kind;
      out_data_r <= OUT_DATA_W'({wheel, header_r[BTN_W-1:0], cur_y_nxt, cur_x_nxt});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/core/ps2_mouse_packet_decoder.sv
// channel   direction  payload
// in_       slave      tdata[7:0] rx_byte
// out_      master     tdata pos_x, pos_y, buttons, wheel; tuser kind
// cfg_      slave      cfg_index register, cfg_data value
//
// one byte per cycle sustained while results are taken and no recenter is
// pending; a byte passes an input register and the packet decode into the
// result register. reset (rst_n low, synchronous) returns to waiting for the
// acknowledge byte with the cursor at the screen center; no clearing pass.
// a stalled result holds the byte in the input register until it is taken.
// a screen size write holds the decode while its recenter strobe is high.
module ps2_mouse_packet_decoder
  import ps2m_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,    // [7:0] rx_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // [11:0] pos_x, [23:12] pos_y,
                                             // [26:24] buttons, [30:27] wheel
  output logic                  out_tuser,   // [0] kind
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t              cfg;
  logic              item_valid;
  logic [BYTE_W-1:0] item_byte;
  logic              item_take;

  ps2m_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ps2m_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .item_valid (item_valid),
    .item_byte  (item_byte),
    .item_take  (item_take)
  );

  ps2m_decode u_dec (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_byte  (item_byte),
    .item_take  (item_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule
